// File: sv/mce_pkg.sv
// shared types, constants and character table of the morse code encoder
package mce_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned UNITS_W = 3;
  localparam int unsigned PAT_W = 5;
  localparam int unsigned LEN_W = 3;

  localparam logic [UNITS_W-1:0] DOT_UNITS = 3'd1;
  localparam logic [UNITS_W-1:0] DASH_UNITS = 3'd3;
  localparam logic [UNITS_W-1:0] ELEM_GAP_UNITS = 3'd1;
  localparam logic [UNITS_W-1:0] LETTER_GAP_UNITS = 3'd3;
  localparam logic [UNITS_W-1:0] WORD_GAP_UNITS = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_CODE,
    KIND_SPACE,
    KIND_UNKNOWN
  } kind_t;

  // pat: first element in bit 0, 1 = dash
  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  len;
    logic [PAT_W-1:0]  pat;
  } code_t;

  typedef struct packed {
    logic               level;
    logic [UNITS_W-1:0] units;
    logic               unk;
    logic               last;
  } seg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ELEM,
    ST_WORD,
    ST_LGAP
  } st_t;

  function automatic code_t code_lookup(input logic [CHAR_W-1:0] c);
    code_t r;
    r.kind = KIND_CODE;
    r.len  = 3'd0;
    r.pat  = 5'b00000;
    case (c)
      8'h41: begin r.len = 3'd2; r.pat = 5'b00010; end // A
      8'h42: begin r.len = 3'd4; r.pat = 5'b00001; end // B
      8'h43: begin r.len = 3'd4; r.pat = 5'b00101; end // C
      8'h44: begin r.len = 3'd3; r.pat = 5'b00001; end // D
      8'h45: begin r.len = 3'd1; r.pat = 5'b00000; end // E
      8'h46: begin r.len = 3'd4; r.pat = 5'b00100; end // F
      8'h47: begin r.len = 3'd3; r.pat = 5'b00011; end // G
      8'h48: begin r.len = 3'd4; r.pat = 5'b00000; end // H
      8'h49: begin r.len = 3'd2; r.pat = 5'b00000; end // I
      8'h4A: begin r.len = 3'd4; r.pat = 5'b01110; end // J
      8'h4B: begin r.len = 3'd3; r.pat = 5'b00101; end // K
      8'h4C: begin r.len = 3'd4; r.pat = 5'b00010; end // L
      8'h4D: begin r.len = 3'd2; r.pat = 5'b00011; end // M
      8'h4E: begin r.len = 3'd2; r.pat = 5'b00001; end // N
      8'h4F: begin r.len = 3'd3; r.pat = 5'b00111; end // O
      8'h50: begin r.len = 3'd4; r.pat = 5'b00110; end // P
      8'h51: begin r.len = 3'd4; r.pat = 5'b01011; end // Q
      8'h52: begin r.len = 3'd3; r.pat = 5'b00010; end // R
      8'h53: begin r.len = 3'd3; r.pat = 5'b00000; end // S
      8'h54: begin r.len = 3'd1; r.pat = 5'b00001; end // T
      8'h55: begin r.len = 3'd3; r.pat = 5'b00100; end // U
      8'h56: begin r.len = 3'd4; r.pat = 5'b01000; end // V
      8'h57: begin r.len = 3'd3; r.pat = 5'b00110; end // W
      8'h58: begin r.len = 3'd4; r.pat = 5'b01001; end // X
      8'h59: begin r.len = 3'd4; r.pat = 5'b01101; end // Y
      8'h5A: begin r.len = 3'd4; r.pat = 5'b00011; end // Z
      8'h30: begin r.len = 3'd5; r.pat = 5'b11111; end // 0
      8'h31: begin r.len = 3'd5; r.pat = 5'b11110; end // 1
      8'h32: begin r.len = 3'd5; r.pat = 5'b11100; end // 2
      8'h33: begin r.len = 3'd5; r.pat = 5'b11000; end // 3
      8'h34: begin r.len = 3'd5; r.pat = 5'b10000; end // 4
      8'h35: begin r.len = 3'd5; r.pat = 5'b00000; end // 5
      8'h36: begin r.len = 3'd5; r.pat = 5'b00001; end // 6
      8'h37: begin r.len = 3'd5; r.pat = 5'b00011; end // 7
      8'h38: begin r.len = 3'd5; r.pat = 5'b00111; end // 8
      8'h39: begin r.len = 3'd5; r.pat = 5'b01111; end // 9
      CHAR_SPACE: begin r.kind = KIND_SPACE; end
      default: begin r.kind = KIND_UNKNOWN; end
    endcase
    return r;
  endfunction

endpackage

// File: sv/morse_code_encoder_unit.sv
// top level of the morse code encoder: input handshake, sequencer and output register
//
// channel | dir | tdata                      | tuser            | tlast
// in_     | in  | [7:0] char_code            | -                | -
// out_    | out | [0] level, [3:1] units     | [0] unknown_char | last segment
//
// a character is loaded while the sequencer is idle, then its segments (1 to 10 segments)
// come out of the sequencer in order, set by the element count and the element shift register
// a new character is taken once the sequencer has handed over the letter gap,
// while that gap may still sit in the output register
// a stall on out_tready holds the output register and freezes the sequencer
// rst_n is synchronous and active low; it empties the sequencer and the output
module morse_code_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] level, [3:1] units, [7:4] zero
  output logic       out_tuser,  // [0] unknown_char
  output logic       out_tlast   // final segment of the character
);

  // sequencer side
  logic          seq_idle;
  logic          seg_valid;
  logic          seg_ready;
  mce_pkg::seg_t seg;
  logic          in_acc;

  // output register
  logic          out_valid_r, out_valid_nxt;
  mce_pkg::seg_t out_seg_r, out_seg_nxt;

  assign in_tready = seq_idle;
  assign in_acc    = in_tvalid && seq_idle;

  mce_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .load_char (in_tdata),
    .idle      (seq_idle),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg)
  );

  // the output register takes a new segment when empty or being drained
  assign seg_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_seg_nxt   = out_seg_r;
    if (seg_ready) begin
      out_valid_nxt = seg_valid;
      out_seg_nxt   = seg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_seg_r <= out_seg_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_seg_r.units, out_seg_r.level};
  assign out_tuser  = out_seg_r.unk;
  assign out_tlast  = out_seg_r.last;

  a_one_char_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second character taken while one is in progress");

  a_unknown_only_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata[0] == 1'b0)
    else $error("unknown character produced a keyed segment");

  a_level_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      out_tdata[3:1] == mce_pkg::DOT_UNITS || out_tdata[3:1] == mce_pkg::DASH_UNITS)
    else $error("keyed segment with a length other than dot or dash");

endmodule

// File: sv/mce_seq.sv
// segment sequencer: shifts the element pattern out one element per segment
module mce_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [mce_pkg::CHAR_W-1:0]  load_char,
  output logic                        idle,
  output logic                        seg_valid,
  input  logic                        seg_ready,
  output mce_pkg::seg_t               seg
);

  mce_pkg::st_t                     state_r, state_nxt;
  logic [mce_pkg::PAT_W-1:0]        pat_r, pat_nxt;
  logic [mce_pkg::LEN_W-1:0]        cnt_r, cnt_nxt;
  logic                             gap_r, gap_nxt;
  logic                             unk_r, unk_nxt;
  mce_pkg::code_t                   code;

  assign code = mce_pkg::code_lookup(load_char);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mce_pkg::ST_IDLE;
      cnt_r   <= '0;
      gap_r   <= 1'b0;
      unk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      gap_r   <= gap_nxt;
      unk_r   <= unk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pat_nxt   = pat_r;
    cnt_nxt   = cnt_r;
    gap_nxt   = gap_r;
    unk_nxt   = unk_r;
    idle      = 1'b0;
    seg_valid = 1'b0;
    seg       = '0;
    case (state_r)
      mce_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (load) begin
          pat_nxt = code.pat;
          cnt_nxt = code.len;
          gap_nxt = 1'b0;
          unk_nxt = 1'b0;
          case (code.kind)
            mce_pkg::KIND_CODE:  state_nxt = mce_pkg::ST_ELEM;
            mce_pkg::KIND_SPACE: state_nxt = mce_pkg::ST_WORD;
            default: begin
              state_nxt = mce_pkg::ST_LGAP;
              unk_nxt   = 1'b1;
            end
          endcase
        end
      end
      mce_pkg::ST_ELEM: begin
        seg_valid = 1'b1;
        if (gap_r) begin
          seg.units = mce_pkg::ELEM_GAP_UNITS;
        end else begin
          seg.level = 1'b1;
          seg.units = pat_r[0] ? mce_pkg::DASH_UNITS : mce_pkg::DOT_UNITS;
        end
        if (seg_ready) begin
          if (gap_r) begin
            gap_nxt = 1'b0;
          end else begin
            pat_nxt = {1'b0, pat_r[mce_pkg::PAT_W-1:1]};
            cnt_nxt = cnt_r - 3'd1;
            if (cnt_r == 3'd1) begin
              state_nxt = mce_pkg::ST_LGAP;
            end else begin
              gap_nxt = 1'b1;
            end
          end
        end
      end
      mce_pkg::ST_WORD: begin
        seg_valid = 1'b1;
        seg.units = mce_pkg::WORD_GAP_UNITS;
        if (seg_ready) begin
          state_nxt = mce_pkg::ST_LGAP;
        end
      end
      mce_pkg::ST_LGAP: begin
        seg_valid = 1'b1;
        seg.units = mce_pkg::LETTER_GAP_UNITS;
        seg.unk   = unk_r;
        seg.last  = 1'b1;
        if (seg_ready) begin
          state_nxt = mce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mce_pkg::ST_IDLE;
      end
    endcase
  end

  a_elem_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mce_pkg::ST_ELEM |-> cnt_r != 3'd0)
    else $error("element state with no elements left");

  a_last_is_gap: assert property (@(posedge clk) disable iff (!rst_n)
    seg_valid && seg.last |-> !seg.level && seg.units == mce_pkg::LETTER_GAP_UNITS)
    else $error("final segment is not the letter gap");

  a_unknown_load: assert property (@(posedge clk) disable iff (!rst_n)
    idle && load && code.kind == mce_pkg::KIND_UNKNOWN
      |=> state_r == mce_pkg::ST_LGAP && unk_r)
    else $error("unknown character did not go straight to letter gap");

endmodule

// File: tb/sv/morse_code_encoder_unit_test.sv
// self-checking testbench of the morse code encoder: stream driver, segment predictor, monitor
module morse_code_encoder_unit_test;

  localparam int unsigned CLK_PERIOD = 12;
  localparam int unsigned RANDOM_CHARS = 145;
  localparam int unsigned LONG_HOLD = 150;       // receiver blackout, long enough to back up the input
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned TIMEOUT_CYCLES = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  // characters still to be offered, and the segments the encoder owes us, oldest first
  logic [7:0]     chars_pending[$];
  mce_pkg::seg_t  segs_owed[$];

  int unsigned chars_total = 0;
  int unsigned chars_taken = 0;
  int unsigned unknown_taken = 0;
  int unsigned segs_seen = 0;
  int unsigned n_errors = 0;
  int unsigned in_stalls = 0;      // cycles the encoder refused an offered item
  bit          long_hold_done = 1'b0;

  morse_code_encoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // segment predictor
  // ---------------------------------------------------------------------------

  // dot/dash string of a character, empty when it has no morse code
  function automatic string morse_pattern(input logic [7:0] c);
    case (c)
      "A": return ".-";     "B": return "-...";   "C": return "-.-.";
      "D": return "-..";    "E": return ".";      "F": return "..-.";
      "G": return "--.";    "H": return "....";   "I": return "..";
      "J": return ".---";   "K": return "-.-";    "L": return ".-..";
      "M": return "--";     "N": return "-.";     "O": return "---";
      "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
      "S": return "...";    "T": return "-";      "U": return "..-";
      "V": return "...-";   "W": return ".--";    "X": return "-..-";
      "Y": return "-.--";   "Z": return "--..";
      "0": return "-----";  "1": return ".----";  "2": return "..---";
      "3": return "...--";  "4": return "....-";  "5": return ".....";
      "6": return "-....";  "7": return "--...";  "8": return "---..";
      "9": return "----.";
      default: return "";
    endcase
  endfunction

  function automatic mce_pkg::seg_t make_seg(input logic lvl,
                                             input logic [mce_pkg::UNITS_W-1:0] len,
                                             input logic unk, input logic fin);
    mce_pkg::seg_t s;
    s.level = lvl;
    s.units = len;
    s.unk   = unk;
    s.last  = fin;
    return s;
  endfunction

  // queue the keying segments one accepted character must produce
  task automatic encode_char(input logic [7:0] c);
    string pat;
    pat = morse_pattern(c);
    if (pat.len() > 0) begin
      for (int i = 0; i < pat.len(); i++) begin
        // element gap between marks, never before the first one
        if (i > 0) segs_owed.push_back(make_seg(1'b0, mce_pkg::ELEM_GAP_UNITS, 1'b0, 1'b0));
        segs_owed.push_back(make_seg(1'b1,
                                     (pat[i] == "-") ? mce_pkg::DASH_UNITS : mce_pkg::DOT_UNITS,
                                     1'b0, 1'b0));
      end
      segs_owed.push_back(make_seg(1'b0, mce_pkg::LETTER_GAP_UNITS, 1'b0, 1'b1));
    end else if (c == mce_pkg::CHAR_SPACE) begin
      // word gap, then the usual letter gap
      segs_owed.push_back(make_seg(1'b0, mce_pkg::WORD_GAP_UNITS, 1'b0, 1'b0));
      segs_owed.push_back(make_seg(1'b0, mce_pkg::LETTER_GAP_UNITS, 1'b0, 1'b1));
    end else begin
      // no code: just the letter gap, flagged
      segs_owed.push_back(make_seg(1'b0, mce_pkg::LETTER_GAP_UNITS, 1'b1, 1'b1));
      unknown_taken++;
    end
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: offers characters from chars_pending with random gaps
  // ---------------------------------------------------------------------------
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;   // items left in a gap-free burst

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // an item moves on this edge: predict its segments right away
      if (in_tvalid && in_tready) begin
        encode_char(in_tdata);
        chars_taken++;
      end
      if (in_tvalid && !in_tready) in_stalls++;
      // the bus is free once nothing is on offer or the offer was just taken
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (chars_pending.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= chars_pending.pop_front();
          if (in_calm > 0) begin
            in_calm--;
          end else begin
            in_gap = idle_len();
            if ($urandom_range(0, 19) == 0) in_calm = $urandom_range(15, 40);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: random back-pressure, one long blackout, field checks
  // ---------------------------------------------------------------------------
  int unsigned out_hold = 0;
  int unsigned out_calm = 0;  // cycles left with out_tready pinned high

  always @(posedge clk) begin
    mce_pkg::seg_t got;
    mce_pkg::seg_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.level = out_tdata[0];
        got.units = out_tdata[3:1];
        got.unk   = out_tuser;
        got.last  = out_tlast;
        segs_seen++;
        if (segs_owed.size() == 0) begin
          n_errors++;
          $display("%0t: segment with none expected, got level=%0b units=%0d unk=%0b last=%0b",
                   $time, got.level, got.units, got.unk, got.last);
        end else begin
          want = segs_owed.pop_front();
          if (got.level !== want.level || got.units !== want.units ||
              got.unk !== want.unk || got.last !== want.last) begin
            n_errors++;
            $display({"%0t: segment mismatch, expected level=%0b units=%0d unk=%0b last=%0b,",
                      " got level=%0b units=%0d unk=%0b last=%0b"},
                     $time, want.level, want.units, want.unk, want.last,
                     got.level, got.units, got.unk, got.last);
          end
        end
      end

      // one long blackout once traffic is flowing, so the encoder fills up and stalls in_
      if (!long_hold_done && segs_seen >= 60) begin
        long_hold_done = 1'b1;
        out_hold = LONG_HOLD;
      end

      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_calm > 0) begin
          out_calm--;
        end else begin
          out_hold = idle_len();
          if ($urandom_range(0, 29) == 0) out_calm = $urandom_range(20, 60);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  task automatic queue_char(input logic [7:0] c);
    chars_pending.push_back(c);
    chars_total++;
  endtask

  initial begin
    logic [7:0] c;
    int unsigned pick;

    // directed: alphabet and digit extremes, longest codes, the repaired letters,
    // space, lowercase, control codes, punctuation next to the ranges, high codes
    queue_char("A"); queue_char("Z"); queue_char("E"); queue_char("T");
    queue_char("0"); queue_char("9"); queue_char("5"); queue_char("1");
    queue_char("G"); queue_char("H"); queue_char("C"); queue_char("Y");
    queue_char("U"); queue_char("Q");
    queue_char(mce_pkg::CHAR_SPACE);
    queue_char("a"); queue_char("z");
    queue_char(8'h00); queue_char(8'hFF); queue_char(8'h7F); queue_char(8'h80);
    queue_char("@"); queue_char("["); queue_char("/"); queue_char(":");

    // random: mostly valid characters so long codes dominate, some arbitrary bytes
    for (int i = 0; i < RANDOM_CHARS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      c = 8'h41 + 8'($urandom_range(0, 25));
      else if (pick < 65) c = 8'h30 + 8'($urandom_range(0, 9));
      else if (pick < 72) c = mce_pkg::CHAR_SPACE;
      else                c = 8'($urandom_range(0, 255));
      queue_char(c);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (chars_taken < chars_total) @(posedge clk);
    while (segs_owed.size() > 0) @(posedge clk);
    // let any stray segment show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d characters (%0d without a code), %0d segments checked",
             chars_taken, unknown_taken, segs_seen);
    $display("input was held off for %0d cycles, long output blackout %0s",
             in_stalls, long_hold_done ? "done" : "not reached");
    if (n_errors == 0) begin
      $display("morse_code_encoder_unit_test OK");
    end else begin
      $display("%0d errors", n_errors);
      $display("morse_code_encoder_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("%0t: timeout, %0d of %0d characters taken, %0d segments owed",
             $time, chars_taken, chars_total, segs_owed.size());
    $display("morse_code_encoder_unit_test NOT OK");
    $finish;
  end

endmodule
